[sv/protobuf_varint_fixed_decoder_top_macros.svh]
// Assertion macros shared by the protobuf varint/fixed decoder checker.
// No dependencies; the user supplies a clock i_clk and reset i_rst_n in scope.
`ifndef PROTOBUF_VARINT_FIXED_DECODER_TOP_MACROS_SVH
`define PROTOBUF_VARINT_FIXED_DECODER_TOP_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define PVD_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("pvd assertion failed");

// Next-cycle implication, checked outside reset.
`define PVD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("pvd assertion failed");

`endif

[sv/pvd_pkg.sv]
// Shared types and codes for the protobuf varint/fixed decoder.
// No dependencies.
package pvd_pkg;

    typedef enum logic [2:0] {
        K_VARINT32 = 3'd0,
        K_VARINT64 = 3'd1,
        K_FIXED32  = 3'd2,
        K_FIXED64  = 3'd3,
        K_BOOL     = 3'd4
    } t_kind;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_MALFORMED = 2'd1,
        ST_TRUNCATED = 2'd2
    } t_status;

    // One buffered input byte with its side fields.
    typedef struct packed {
        logic       valid;
        logic [2:0] operation;
        logic [7:0] data_byte;
        logic       end_of_buffer;
    } t_item;

    localparam int unsigned VAL_W   = 64;
    localparam int unsigned CNT_W   = 4;
    localparam int unsigned SHIFT_W = 6;

endpackage

[sv/protobuf_varint_fixed_decoder_top.sv]
// Top level of the protobuf varint/fixed wire-value decoder.
// Depends on pvd_pkg, pvd_in_reg and pvd_core.
//
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+--------------------------------------
//  in      | sink      | i_in_valid / o_in_stall | i_operation, i_data_byte, i_end_of_buffer
//  out     | source    | o_out_valid / i_out_stall | o_value, o_status
//
// One byte per cycle sustained while the result register is not stalled. A byte lands in the input
// register at its transfer edge; the core folds it from there into the result register, and
// o_out_valid rises when the completing byte's result is loaded there.
// Synchronous active-low reset clears the pipeline valids and puts the decoder
// between values. A stalled result holds its register; the input side keeps
// taking bytes until the held byte itself cannot move.
module protobuf_varint_fixed_decoder_top (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [2:0]         i_operation,
    input  logic [7:0]         i_data_byte,
    input  logic               i_end_of_buffer,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic signed [63:0] o_value,
    output logic [1:0]         o_status
);
    import pvd_pkg::*;

    t_item item;     // byte held in the input register
    logic  adv;      // core can take the held byte this cycle

    pvd_in_reg u_in (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_operation     (i_operation),
        .i_data_byte     (i_data_byte),
        .i_end_of_buffer (i_end_of_buffer),
        .i_adv           (adv),
        .o_item          (item)
    );

    // Kind latched on a value's first byte; each byte folded in one step;
    // a completing byte loads the result register with value and status.
    pvd_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_item      (item),
        .o_adv       (adv),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_value     (o_value),
        .o_status    (o_status)
    );

endmodule

[sv/pvd_in_reg.sv]
// Input register stage of the protobuf decoder.
// Depends on pvd_pkg (t_item).
module pvd_in_reg (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    input  logic [2:0]    i_operation,
    input  logic [7:0]    i_data_byte,
    input  logic          i_end_of_buffer,
    input  logic          i_adv,
    output pvd_pkg::t_item o_item
);
    import pvd_pkg::*;

    logic       r_valid;
    logic [2:0] r_operation;
    logic [7:0] r_data_byte;
    logic       r_eob;

    // Held byte blocks new transfers only while the core cannot take it.
    assign o_in_stall = r_valid && !i_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_operation <= i_operation;
            r_data_byte <= i_data_byte;
            r_eob       <= i_end_of_buffer;
        end
    end

    assign o_item = '{valid: r_valid, operation: r_operation,
                      data_byte: r_data_byte, end_of_buffer: r_eob};

endmodule

[sv/pvd_core.sv]
// Decode core: value state, byte fold and result register.
// Depends on pvd_pkg (kinds, status codes, t_item).
module pvd_core (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  pvd_pkg::t_item        i_item,
    output logic                  o_adv,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic signed [63:0]    o_value,
    output logic [1:0]            o_status
);
    import pvd_pkg::*;

    logic [VAL_W-1:0]   r_acc,   n_acc;
    logic [CNT_W-1:0]   r_cnt,   n_cnt;
    logic [2:0]         r_kind,  n_kind;
    logic               r_in_value;
    logic               r_res_valid;
    logic [VAL_W-1:0]   r_value, n_value;
    logic [1:0]         r_status;
    t_status            n_status;

    logic               fire;
    logic               first;
    logic [VAL_W-1:0]   acc0;
    logic [CNT_W-1:0]   n;
    logic [SHIFT_W-1:0] sh7;
    logic [SHIFT_W-1:0] sh8;
    logic [VAL_W-1:0]   b7, b8, b4;
    logic               more;
    logic               done;

    assign o_adv = !r_res_valid || !i_out_stall;
    assign fire  = i_item.valid && o_adv;
    assign first = !r_in_value;
    assign acc0  = first ? '0 : r_acc;
    assign n     = first ? '0 : r_cnt;
    assign more  = i_item.data_byte[7];

    // 7*n and 8*n as shift amounts; n never exceeds nine.
    assign sh7 = SHIFT_W'({n, 3'b000} - {3'b000, n});
    assign sh8 = SHIFT_W'({n[2:0], 3'b000});
    assign b7  = {57'b0, i_item.data_byte[6:0]};
    assign b8  = {56'b0, i_item.data_byte};
    assign b4  = {60'b0, i_item.data_byte[3:0]};

    always_comb begin
        n_kind   = first ? i_item.operation : r_kind;
        n_acc    = acc0;
        done     = 1'b0;
        n_status = ST_OK;
        case (n_kind)
            K_VARINT64: begin
                if (n <= CNT_W'(9)) n_acc = acc0 | (b7 << sh7);
                if (!more) begin
                    done = 1'b1;
                end else if (n >= CNT_W'(9)) begin
                    done     = 1'b1;
                    n_status = ST_MALFORMED;
                end
            end
            K_FIXED32: begin
                n_acc = acc0 | (b8 << {1'b0, sh8[4:0]});
                done  = n >= CNT_W'(3);
            end
            K_FIXED64: begin
                n_acc = acc0 | (b8 << sh8);
                done  = n >= CNT_W'(7);
            end
            default: begin
                if (n < CNT_W'(4)) begin
                    n_acc = acc0 | (b7 << sh7);
                end else if (n == CNT_W'(4)) begin
                    n_acc = acc0 | (b4 << 28);
                end
                n_acc = {32'b0, n_acc[31:0]};
                if (!more) begin
                    done = 1'b1;
                end else if (n >= CNT_W'(9)) begin
                    done     = 1'b1;
                    n_status = ST_MALFORMED;
                end
            end
        endcase
        if (!done && i_item.end_of_buffer) begin
            done     = 1'b1;
            n_status = ST_TRUNCATED;
        end
        n_cnt = done ? '0 : n + CNT_W'(1);
    end

    always_comb begin
        case (n_kind)
            K_VARINT64: n_value = (n_status == ST_MALFORMED) ? '0 : n_acc;
            K_FIXED64:  n_value = n_acc;
            K_BOOL:     n_value = {63'b0, |n_acc[31:0]};
            default:    n_value = {{32{n_acc[31]}}, n_acc[31:0]};
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_value  <= 1'b0;
            r_cnt       <= '0;
            r_kind      <= K_VARINT32;
            r_acc       <= '0;
            r_res_valid <= 1'b0;
        end else begin
            if (fire) begin
                r_in_value <= !done;
                r_cnt      <= n_cnt;
                r_kind     <= n_kind;
                r_acc      <= n_acc;
            end
            if (o_adv) begin
                r_res_valid <= fire && done;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire && done) begin
            r_value  <= n_value;
            r_status <= n_status;
        end
    end

    assign o_out_valid = r_res_valid;
    assign o_value     = r_value;
    assign o_status    = r_status;

endmodule

[sv/pvd_checker.sv]
// Port-level checks for the protobuf decoder, bound to the top level.
// Depends on pvd_pkg and protobuf_varint_fixed_decoder_top_macros.svh.
`include "protobuf_varint_fixed_decoder_top_macros.svh"

module pvd_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_stall,
    input logic [2:0]  i_operation,
    input logic [7:0]  i_data_byte,
    input logic        i_end_of_buffer,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic [63:0] o_value,
    input logic [1:0]  o_status
);
    import pvd_pkg::*;

    logic        known_status;
    logic        out_held;
    logic        in_held;
    logic [11:0] in_fields;

    assign known_status = (o_status == ST_OK) || (o_status == ST_MALFORMED) ||
                          (o_status == ST_TRUNCATED);
    assign out_held     = o_out_valid && i_out_stall;
    assign in_held      = i_in_valid && o_in_stall;
    assign in_fields    = {i_operation, i_data_byte, i_end_of_buffer};

    // Only defined status codes leave the block.
    `PVD_ASSERT_NOW(a_status_code, o_out_valid, known_status)

    // Input back-pressure only ever comes from a stalled, full result register.
    `PVD_ASSERT_NOW(a_stall_source, o_in_stall, (o_out_valid && i_out_stall))

    // A stalled result stays put.
    `PVD_ASSERT_NEXT(a_out_hold, out_held, (o_out_valid && $stable(o_value) && $stable(o_status)))

    // A stalled input transfer stays offered and unchanged.
    `PVD_ASSERT_NEXT(a_in_hold, in_held, (i_in_valid && $stable(in_fields)))

endmodule

bind protobuf_varint_fixed_decoder_top pvd_checker u_pvd_checker (.*);

[test/tb_top.sv]
// Self-checking testbench for protobuf_varint_fixed_decoder_top.
// Depends on pvd_pkg and the decoder RTL. A built-in predictor scores every result.
`timescale 1ns / 1ps

import pvd_pkg::*;

// Mirrors the decoder state and queues up the values it should emit.
class dec_check;
    logic [63:0] acc;
    logic [3:0]  taken;
    logic [2:0]  kind;
    bit          busy;

    logic [63:0] pending_value[$];
    t_status     pending_status[$];

    int values_seen;
    int malformed_seen;
    int truncated_seen;
    int mismatches;

    function void take_byte(input logic [2:0] op, input logic [7:0] b, input logic eob);
        logic [63:0] group7;
        logic [63:0] whole;
        logic [63:0] result;
        logic        done;
        t_status     st;
        int          n;
        if (!busy) begin
            kind  = op;
            acc   = '0;
            taken = '0;
            busy  = 1'b1;
        end
        n      = taken;
        group7 = {57'd0, b[6:0]};
        whole  = {56'd0, b};
        done   = 1'b0;
        st     = ST_OK;
        case (kind)
            K_VARINT64: begin
                if (n <= 9) acc |= group7 << (7 * n);
                if (!b[7]) begin
                    done = 1'b1;
                end else if (n >= 9) begin
                    done = 1'b1;
                    st   = ST_MALFORMED;
                end
            end
            K_FIXED32: begin
                acc |= whole << (8 * (n % 4));
                done = (n >= 3);
            end
            K_FIXED64: begin
                acc |= whole << (8 * (n % 8));
                done = (n >= 7);
            end
            default: begin
                // 32-bit varints: fifth byte keeps only its low nibble, tail is dropped
                if (n < 4) acc |= group7 << (7 * n);
                else if (n == 4) acc |= {60'd0, b[3:0]} << 28;
                acc[63:32] = '0;
                if (!b[7]) begin
                    done = 1'b1;
                end else if (n >= 9) begin
                    done = 1'b1;
                    st   = ST_MALFORMED;
                end
            end
        endcase
        if (!done && eob) begin
            done = 1'b1;
            st   = ST_TRUNCATED;
        end
        if (!done) begin
            taken = taken + 1'b1;
            return;
        end
        case (kind)
            K_VARINT64: result = (st == ST_MALFORMED) ? 64'd0 : acc;
            K_FIXED64:  result = acc;
            K_BOOL:     result = (acc[31:0] != 32'd0) ? 64'd1 : 64'd0;
            default:    result = {{32{acc[31]}}, acc[31:0]};
        endcase
        pending_value.push_back(result);
        pending_status.push_back(st);
        busy  = 1'b0;
        taken = '0;
    endfunction

    function void check_result(input logic [63:0] v, input logic [1:0] s);
        logic [63:0] want_v;
        t_status     want_s;
        if (pending_value.size() == 0) begin
            $display("%0t: unexpected result, value %h status %0d", $time, v, s);
            mismatches++;
            return;
        end
        want_v = pending_value.pop_front();
        want_s = pending_status.pop_front();
        values_seen++;
        if (want_s == ST_MALFORMED) malformed_seen++;
        if (want_s == ST_TRUNCATED) truncated_seen++;
        if (v !== want_v) begin
            $display("%0t: value mismatch, expected %h, got %h", $time, want_v, v);
            mismatches++;
        end
        if (s !== want_s) begin
            $display("%0t: status mismatch, expected %0d, got %0d", $time, want_s, s);
            mismatches++;
        end
    endfunction
endclass

module tb_top;

    // Codes 5..7 are not defined kinds; the decoder treats them as varint32.
    localparam logic [2:0] OP_UNKNOWN = 3'd5;
    localparam int         LIMIT      = 300000;   // cycles before the run is declared hung
    localparam int         LONG_HOLD  = 200;      // receiver hold-off for the back-pressure phase

    logic              i_clk = 1'b0;
    logic              i_rst_n;
    logic              i_in_valid;
    logic              o_in_stall;
    logic [2:0]        i_operation;
    logic [7:0]        i_data_byte;
    logic              i_end_of_buffer;
    logic              o_out_valid;
    logic              i_out_stall;
    logic signed [63:0] o_value;
    logic [1:0]        o_status;

    dec_check sb;
    int       bytes_sent;
    int       cycles;
    bit       in_gaps;        // sender inserts random idle cycles
    bit       out_gaps;       // receiver inserts random stall cycles
    bit       hold_long;      // ask the receiver for one long hold-off

    protobuf_varint_fixed_decoder_top uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_operation     (i_operation),
        .i_data_byte     (i_data_byte),
        .i_end_of_buffer (i_end_of_buffer),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_value         (o_value),
        .o_status        (o_status)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Watchdog: a correct run finishes far inside this.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    // Score every result transfer. All signals change by NBA, so the values
    // read here are the ones the block saw at this edge.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) sb.check_result(o_value, o_status);
    end

    // One input transfer: optional idle gap, then hold the byte until taken.
    task automatic push_byte(input logic [2:0] op, input logic [7:0] b, input logic eob);
        int gap;
        gap = in_gaps ? $urandom_range(0, 4) : 0;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid      <= 1'b1;
        i_operation     <= op;
        i_data_byte     <= b;
        i_end_of_buffer <= eob;
        do @(posedge i_clk); while (o_in_stall);
        sb.take_byte(op, b, eob);
        bytes_sent++;
    endtask

    // A well-formed value of the given kind with random content; sometimes
    // cut short by end of buffer, sometimes an over-long varint.
    task automatic push_value(input logic [2:0] op);
        int         len;
        int         cut;
        bit         last_cont;
        bit         blank;
        bit         fixed_kind;
        logic [7:0] b;
        logic       eob;
        fixed_kind = (op == K_FIXED32) || (op == K_FIXED64);
        last_cont  = 1'b0;
        case (op)
            K_FIXED32: len = 4;
            K_FIXED64: len = 8;
            default: begin
                if ($urandom_range(0, 7) == 0) begin
                    len       = 10;
                    last_cont = 1'b1;
                end else begin
                    len = ($urandom_range(0, 3) == 0) ? $urandom_range(6, 10)
                                                      : $urandom_range(1, 5);
                end
            end
        endcase
        cut   = ($urandom_range(0, 7) == 0) ? $urandom_range(0, len - 1) : -1;
        blank = ($urandom_range(0, 7) == 0);
        for (int i = 0; i < len; i++) begin
            if (fixed_kind) begin
                b = blank ? 8'd0 : 8'($urandom_range(0, 255));
            end else begin
                b[6:0] = blank ? 7'd0 : 7'($urandom_range(0, 127));
                b[7]   = (i < len - 1) || last_cont;
            end
            eob = (i == cut) || ((i == len - 1) && ($urandom_range(0, 7) == 0));
            // operation only matters on the first byte; scramble it elsewhere
            push_byte((i == 0) ? op : 3'($urandom_range(0, 7)), b, eob);
            if (i == cut) break;
        end
    endtask

    // Raw noise: arbitrary bytes, kinds and end markers.
    task automatic push_junk();
        int n;
        n = $urandom_range(1, 6);
        repeat (n) push_byte(3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)),
                             $urandom_range(0, 3) == 0);
    endtask

    task automatic random_until(input int target);
        logic [2:0] op;
        while (bytes_sent < target) begin
            if ($urandom_range(0, 9) == 0) begin
                push_junk();
            end else begin
                op = ($urandom_range(0, 9) < 8) ? 3'($urandom_range(0, 4))
                                                : 3'($urandom_range(5, 7));
                push_value(op);
            end
        end
    endtask

    // Receiver: per result, stall for a random count of cycles, then accept.
    // A long hold-off, when asked for, is timed here while the sender carries on.
    initial begin : result_sink
        int wait_cycles;
        wait (i_rst_n === 1'b1);
        forever begin
            if (hold_long) begin
                wait_cycles = LONG_HOLD;
                hold_long   = 1'b0;
            end else begin
                wait_cycles = out_gaps ? $urandom_range(0, 4) : 0;
            end
            if (wait_cycles > 0) begin
                i_out_stall <= 1'b1;
                repeat (wait_cycles) @(posedge i_clk);
            end
            i_out_stall <= 1'b0;
            do @(posedge i_clk); while (!o_out_valid);
        end
    end

    initial begin
        sb              = new();
        bytes_sent      = 0;
        cycles          = 0;
        in_gaps         = 1'b1;
        out_gaps        = 1'b1;
        hold_long       = 1'b0;
        i_rst_n         <= 1'b0;
        i_in_valid      <= 1'b0;
        i_operation     <= K_VARINT32;
        i_data_byte     <= 8'd0;
        i_end_of_buffer <= 1'b0;
        i_out_stall     <= 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // --- directed ---
        // varint32 of -1: fifth byte's upper bits must be dropped
        push_byte(K_VARINT32, 8'hff, 1'b0);
        push_byte(K_FIXED64,  8'hff, 1'b0);
        push_byte(K_FIXED32,  8'hff, 1'b0);
        push_byte(K_BOOL,     8'hff, 1'b0);
        push_byte(K_VARINT64, 8'h7f, 1'b0);
        // varint64 whose tenth byte still carries a continuation: malformed, value 0
        push_byte(K_VARINT64, 8'h80, 1'b0);
        repeat (8) push_byte(K_BOOL, 8'h80, 1'b0);
        push_byte(K_FIXED32, 8'h81, 1'b0);
        // fixed32 with only the sign bit set, sign-extended
        push_byte(K_FIXED32, 8'h00, 1'b0);
        push_byte(K_VARINT32, 8'h00, 1'b0);
        push_byte(K_VARINT32, 8'h00, 1'b0);
        push_byte(K_VARINT32, 8'h80, 1'b0);
        // fixed64 cut off after two bytes
        push_byte(K_FIXED64, 8'hff, 1'b0);
        push_byte(K_FIXED64, 8'hff, 1'b1);
        // bool zero, with end of buffer on the completing byte (still ok)
        push_byte(K_BOOL, 8'h00, 1'b1);
        // undefined kind decodes as varint32
        push_byte(OP_UNKNOWN, 8'h7f, 1'b0);
        // varint32 truncated on its first byte
        push_byte(K_VARINT32, 8'h80, 1'b1);

        // --- random, both sides idling ---
        random_until(700);

        // --- random, back to back ---
        in_gaps  = 1'b0;
        out_gaps = 1'b0;
        random_until(1100);

        // --- back-pressure: receiver holds off, sender keeps offering ---
        hold_long = 1'b1;
        random_until(1300);

        // --- random, idling again ---
        in_gaps  = 1'b1;
        out_gaps = 1'b1;
        random_until(1650);

        i_in_valid <= 1'b0;
        while (sb.pending_value.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);   // catch any stray result

        $display("Covered %0d input bytes and %0d decoded values", bytes_sent, sb.values_seen);
        $display("  %0d malformed, %0d truncated, %0d mismatches",
                 sb.malformed_seen, sb.truncated_seen, sb.mismatches);
        if (sb.mismatches == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
